/* hw/rtl/depth_sorted_insert_table_macros.svh */
// Assertion macros for the depth sorted insert table.
// Included by the modules that carry concurrent assertions; no dependencies.
`ifndef DEPTH_SORTED_INSERT_TABLE_MACROS_SVH
`define DEPTH_SORTED_INSERT_TABLE_MACROS_SVH

// Overlapping implication, sampled on clk, off during reset.
`define DSIT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define DSIT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/dsit_pkg.sv */
// Shared constants for the depth sorted insert table.
// No dependencies.
`timescale 1ns / 1ps

package dsit_pkg;

    localparam int KEY_W        = 32;
    localparam int POS_W        = 10;
    localparam int CNT_FIELD_W  = 11;
    localparam int DEF_CAPACITY = 1024;

    localparam logic [0:0] KIND_INSERT = 1'b0;
    localparam logic [0:0] KIND_CLEAR  = 1'b1;

endpackage

/* hw/rtl/dsit_req_if.sv */
// Request channel of the depth sorted insert table.
// Depends on dsit_pkg.
`timescale 1ns / 1ps

interface dsit_req_if;
    logic                        valid;
    logic                        ready;
    logic [0:0]                  kind;
    logic [dsit_pkg::KEY_W-1:0]  depth_key;

    modport source (output valid, output kind, output depth_key, input ready);
    modport sink   (input valid, input kind, input depth_key, output ready);
endinterface

/* hw/rtl/dsit_res_if.sv */
// Result channel of the depth sorted insert table.
// Depends on dsit_pkg.
`timescale 1ns / 1ps

interface dsit_res_if;
    logic                              valid;
    logic                              ready;
    logic [dsit_pkg::POS_W-1:0]        position;
    logic                              full_res;
    logic [dsit_pkg::CNT_FIELD_W-1:0]  entry_count;

    modport source (output valid, output position, output full_res, output entry_count,
                    input ready);
    modport sink   (input valid, input position, input full_res, input entry_count,
                    output ready);
endinterface

/* hw/rtl/depth_sorted_insert_table.sv */
// Depth sorted insert table: top level, key memory and sequencer.
// Depends on dsit_pkg, dsit_req_if, dsit_res_if and the assertion macros header.
`timescale 1ns / 1ps
`include "depth_sorted_insert_table_macros.svh"

// Channel | Modport | Payload                              | Notes
// --------+---------+--------------------------------------+-------------------------------
// req     | sink    | kind, depth_key                      | insert key or clear table
// res     | source  | position, full_res, entry_count      | one per request, registered
//
// Sequence: clear and refused (full) requests finish in the accepting cycle.
//   An insert runs a binary search over the n stored keys, each step a memory read
//   (SRCH) then a compare (SWAIT), then moves the tail up one entry at a time
//   through the single read and single write port, writes the key into its slot,
//   then loads the result in DONE, which waits while the output register is held.
// Reset: clears the entry count and control state; the key memory is left as is,
//   since only slots below the count are ever read.
// Stalls: a result waits in the output register; a new request is taken while it
//   waits only if res.ready frees the register in the same cycle.

module depth_sorted_insert_table #(
    parameter int CAPACITY = dsit_pkg::DEF_CAPACITY
) (
    input  logic        clk,
    input  logic        rst_n,
    dsit_req_if.sink    req,
    dsit_res_if.source  res
);

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SRCH  = 3'd1;
    localparam logic [2:0] ST_SWAIT = 3'd2;
    localparam logic [2:0] ST_SHIFT = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    // control state
    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ov_reg, ov_next;        // result register occupied
    logic             pend_reg, pend_next;    // a shift write is waiting for read data

    // payload state
    logic [dsit_pkg::KEY_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0]           lo_reg, lo_next;      // search low bound, later insert slot
    logic [CNT_W-1:0]           hi_reg, hi_next;
    logic [CNT_W-1:0]           mid_reg, mid_next;
    logic [CNT_W-1:0]           idx_reg, idx_next;    // next slot to fill during the shift
    logic [ADDR_W-1:0]          pend_addr_reg, pend_addr_next;
    logic [CNT_W-1:0]           res_pos_reg, res_pos_next;
    logic                       res_full_reg, res_full_next;
    logic [CNT_W-1:0]           res_cnt_reg, res_cnt_next;

    // key memory, one read and one write port, registered read data
    logic [dsit_pkg::KEY_W-1:0] key_mem [CAPACITY];
    logic [dsit_pkg::KEY_W-1:0] rd_data_reg;
    logic                       mem_re, mem_we;
    logic [ADDR_W-1:0]          mem_ra, mem_wa;
    logic [dsit_pkg::KEY_W-1:0] mem_wd;

    logic             req_take;
    logic             res_take;
    logic             res_free;
    logic [CNT_W-1:0] mid_calc;
    logic [31:0]      pos_wide;
    logic [31:0]      cnt_wide;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= key_mem[mem_ra];
        end
    end

    assign res_take = ov_reg && res.ready;
    assign res_free = !ov_reg || res.ready;
    assign req.ready = (state_reg == ST_IDLE) && res_free;
    assign req_take = req.valid && req.ready;
    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ov_next        = ov_reg && !res_take;
        pend_next      = pend_reg;
        key_next       = key_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        idx_next       = idx_reg;
        pend_addr_next = pend_addr_reg;
        res_pos_next   = res_pos_reg;
        res_full_next  = res_full_reg;
        res_cnt_next   = res_cnt_reg;
        mem_re         = 1'b0;
        mem_ra         = mid_calc[ADDR_W-1:0];
        mem_we         = 1'b0;
        mem_wa         = pend_addr_reg;
        mem_wd         = rd_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                begin
                    if (req.kind == dsit_pkg::KIND_CLEAR)
                    begin
                        count_next    = '0;
                        ov_next       = 1'b1;
                        res_pos_next  = '0;
                        res_full_next = 1'b0;
                        res_cnt_next  = '0;
                    end
                    else if (count_reg >= CAP_CNT)
                    begin
                        ov_next       = 1'b1;
                        res_pos_next  = '0;
                        res_full_next = 1'b1;
                        res_cnt_next  = count_reg;
                    end
                    else
                    begin
                        key_next   = req.depth_key;
                        lo_next    = '0;
                        hi_next    = count_reg;
                        state_next = ST_SRCH;
                    end
                end
            end
            ST_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mem_re     = 1'b1;
                    mid_next   = mid_calc;
                    state_next = ST_SWAIT;
                end
                else
                begin
                    idx_next   = count_reg;
                    pend_next  = 1'b0;
                    state_next = ST_SHIFT;
                end
            end
            ST_SWAIT:
            begin
                if (key_reg <= rd_data_reg)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg + 1'b1;
                end
                state_next = ST_SRCH;
            end
            ST_SHIFT:
            begin
                // read slot idx-1 while the previous read lands in its upper neighbour
                if (idx_reg > lo_reg)
                begin
                    mem_re         = 1'b1;
                    mem_ra         = ADDR_W'(idx_reg - 1'b1);
                    mem_we         = pend_reg;
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg[ADDR_W-1:0];
                    idx_next       = idx_reg - 1'b1;
                end
                else if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    pend_next = 1'b0;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_wa     = lo_reg[ADDR_W-1:0];
                    mem_wd     = key_reg;
                    count_next = count_reg + 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_free)
                begin
                    ov_next       = 1'b1;
                    res_pos_next  = lo_reg;
                    res_full_next = 1'b0;
                    res_cnt_next  = count_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        idx_reg       <= idx_next;
        pend_addr_reg <= pend_addr_next;
        res_pos_reg   <= res_pos_next;
        res_full_reg  <= res_full_next;
        res_cnt_reg   <= res_cnt_next;
    end

    // fields wrap to their widths
    assign pos_wide        = 32'(res_pos_reg);
    assign cnt_wide        = 32'(res_cnt_reg);
    assign res.valid       = ov_reg;
    assign res.position    = pos_wide[dsit_pkg::POS_W-1:0];
    assign res.full_res    = res_full_reg;
    assign res.entry_count = cnt_wide[dsit_pkg::CNT_FIELD_W-1:0];

    `DSIT_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CAP_CNT, "entry count above capacity")
    `DSIT_ASSERT_NXT(a_clear_empties, req_take && (req.kind == dsit_pkg::KIND_CLEAR), count_reg == '0 && ov_reg, "clear did not empty the table")
    `DSIT_ASSERT_IMP(a_shift_order, state_reg == ST_SHIFT, idx_reg >= lo_reg && lo_reg <= count_reg, "shift index below insert slot")
    `DSIT_ASSERT_IMP(a_full_slot0, ov_reg && res_full_reg, res_pos_reg == '0 && res_cnt_reg == CAP_CNT, "refused insert with bad result")
    `DSIT_ASSERT_NXT(a_insert_grows, state_reg == ST_SHIFT && state_next == ST_DONE, count_reg == $past(count_reg) + 1'b1, "insert did not grow the table")

endmodule
